// ===== hdl/trial_division_prime_test_top_macros.svh =====
// Assertion macros shared by the trial division prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tdpt_pkg.sv =====
// Package with shared constants and types of the trial division prime test.
`default_nettype none

package tdpt_pkg;

  // Default width of the number under test.
  localparam int unsigned NumberWidthDef = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_STEP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/trial_division_prime_test_top.sv =====
// Trial division prime test with a bit-serial remainder unit.
//
//   channel  direction  signals                          payload
//   in       input      in_valid_i / in_ready_o          candidate_i
//   out      output     out_valid_o / out_ready_i        is_prime_o
//
// Numbers below two, the number two and even numbers need no trial divisions.
// Each odd trial divisor takes one bound compare, NUMBER_WIDTH restoring shift-subtract
// steps of the remainder unit, and one divisor step.
// The worst case is a prime near 2**NUMBER_WIDTH.
// One item is worked on at a time; the next is taken while a result waits.
// Reset is asynchronous and active low and clears the control state only.
`default_nettype none
`include "trial_division_prime_test_top_macros.svh"

module trial_division_prime_test_top #(
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NumberWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [NUMBER_WIDTH-1:0] candidate_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic                    is_prime_o
);

  localparam int unsigned W    = NUMBER_WIDTH;
  localparam int unsigned CntW = $clog2(NUMBER_WIDTH);

  tdpt_pkg::state_e state_q, state_d;

  logic [W-1:0]    n_q, n_d;      // number under test
  logic [W-1:0]    nsh_q, nsh_d;  // dividend bits, shifted out MSB first
  logic [W-1:0]    d_q, d_d;      // current odd trial divisor
  logic [W:0]      sq_q, sq_d;    // square of the trial divisor
  logic [W-1:0]    rem_q, rem_d;  // partial remainder
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic            is_prime_q, is_prime_d;

  logic            accept;
  logic            out_free;
  logic            trivial;
  logic            trivial_res;
  logic            in_bound;
  logic [W:0]      trial;
  logic            fits;

  assign in_ready_o  = (state_q == tdpt_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  // Small and even numbers need no trial divisions.
  always_comb begin
    trivial     = 1'b1;
    trivial_res = 1'b0;
    priority if (candidate_i < W'(2)) begin
      trivial_res = 1'b0;
    end else if (candidate_i == W'(2)) begin
      trivial_res = 1'b1;
    end else if (!candidate_i[0]) begin
      trivial_res = 1'b0;
    end else begin
      trivial = 1'b0;
    end
  end

  assign in_bound = (sq_q <= {1'b0, n_q});
  assign trial    = {rem_q, nsh_q[W-1]};
  assign fits     = (trial >= {1'b0, d_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = trivial ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_CHECK: begin
        state_d = in_bound ? tdpt_pkg::ST_DIVIDE : tdpt_pkg::ST_DONE;
      end
      tdpt_pkg::ST_DIVIDE: begin
        if (cnt_q == '0) begin
          state_d = tdpt_pkg::ST_STEP;
        end
      end
      tdpt_pkg::ST_STEP: begin
        state_d = (rem_q == '0) ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_CHECK;
      end
      tdpt_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tdpt_pkg::ST_IDLE;
        end
      end
      default: state_d = tdpt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    n_d         = n_q;
    nsh_d       = nsh_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (accept) begin
          n_d   = candidate_i;
          res_d = trivial_res;
          d_d   = W'(3);
          sq_d  = (W+1)'(9);
        end
      end
      tdpt_pkg::ST_CHECK: begin
        nsh_d = n_q;
        rem_d = '0;
        cnt_d = CntW'(W - 1);
        // With the bound passed and no divisor found, the number is prime.
        if (!in_bound) begin
          res_d = 1'b1;
        end
      end
      tdpt_pkg::ST_DIVIDE: begin
        rem_d = fits ? W'(trial - {1'b0, d_q}) : trial[W-1:0];
        nsh_d = {nsh_q[W-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
      end
      tdpt_pkg::ST_STEP: begin
        if (rem_q == '0) begin
          res_d = 1'b0;
        end
        // (d + 2)^2 = d^2 + 4d + 4
        sq_d = sq_q + (W+1)'({d_q, 2'b00}) + (W+1)'(4);
        d_d  = d_q + W'(2);
      end
      tdpt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          is_prime_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    nsh_q      <= nsh_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    is_prime_q <= is_prime_d;
  end

  `TDPT_ASSERT_SAME(a_odd_divisor,
    (state_q == tdpt_pkg::ST_DIVIDE || state_q == tdpt_pkg::ST_STEP), d_q[0],
    "trial divisor is not odd")
  `TDPT_ASSERT_SAME(a_rem_below_divisor,
    (state_q == tdpt_pkg::ST_DIVIDE || state_q == tdpt_pkg::ST_STEP), rem_q < d_q,
    "partial remainder is not below the divisor")
  `TDPT_ASSERT_NEXT(a_result_from_done,
    !out_valid_q || out_ready_i,
    !out_valid_q || $past(state_q) == tdpt_pkg::ST_DONE,
    "result shown without a finished item")
  `TDPT_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o,
    "item accepted while another is open")

endmodule

`default_nettype wire
